// File: src/alle_pkg.sv
// Package: request/result types and codes for the array linked list engine.
package alle_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_READ   = 2'd2,
    OP_FIND   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  position;
    logic [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] read_value;
    logic [3:0]  found_position;
    logic [4:0]  entry_count;
    logic        is_full;
    logic        is_empty;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE,
    ST_WALK,
    ST_FETCH,
    ST_LINK,
    ST_FIX,
    ST_DONE
  } state_e;

endpackage

// File: src/array_linked_list_engine.sv
// Top level: array-backed doubly linked list engine with a link-walk sequencer.
//
// Usage: requests enter on req_valid_i/req_ready_o as one req_t transaction
// (op, position, item_value); each produces exactly one rsp_t transaction on
// rsp_valid_o/rsp_ready_i. Insert places a value at a list position (up to
// the count), erase removes the entry at a position, read returns the value
// at a position, and find returns the first position holding a value.
// One request is in flight at a time. The sequencer first scans the slot
// bitmap for the lowest free slot (insert only, one slot per cycle), then
// walks the link array one hop per cycle through a single shared slot
// counter and compare, then, as the op needs, fetches the slot at the
// position, relinks its neighbors in the link and fix states, and loads the
// result in the done state. Reset empties the list (head and tail to none,
// count and used bits cleared); the link and value arrays are not cleared.
// If the receiver stalls, the result is held in the output register; the
// next request is still taken and processed, and its result waits in the
// done state until the held one is accepted.
module array_linked_list_engine
  import alle_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam int SW = $clog2(CAPACITY + 1);  // slot index incl. none marker
  localparam int IW = $clog2(CAPACITY);
  localparam logic [SW-1:0] NONE = SW'(CAPACITY);

  state_e state_q, state_d;

  logic [SW-1:0] head_q, tail_q, cnt_q;
  logic [CAPACITY-1:0] used_q;
  logic [SW-1:0] next_q [CAPACITY];
  logic [SW-1:0] prev_q [CAPACITY];
  logic [DATA_WIDTH-1:0] val_q [CAPACITY];

  op_e           op_q;
  logic [4:0]    pos_q;
  logic [DATA_WIDTH-1:0] v_q;
  logic [SW-1:0] cur_q;    // walk cursor slot / free scan index
  logic [SW-1:0] idx_q;    // hops taken
  logic [SW-1:0] free_q;   // slot chosen for insert; successor slot on erase
  logic [SW-1:0] pred_q;
  logic          ok_q;
  logic [DATA_WIDTH-1:0] rv_q;
  logic [SW-1:0] fp_q;
  rsp_t          rsp_q;
  logic          rsp_valid_q;

  logic [IW-1:0] cur_ix;
  logic          cur_ok;
  logic          accept;
  logic [SW-1:0] pos_ext;

  assign cur_ix  = cur_q[IW-1:0];
  assign cur_ok  = cur_q < NONE;
  assign accept  = req_valid_i && req_ready_o;
  assign pos_ext = (SW >= 5) ? SW'(pos_q) : ((pos_q > 5'(CAPACITY)) ? NONE : SW'(pos_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_FREE;
      end
      ST_FREE: begin
        priority if (op_q == OP_INSERT) begin
          if (32'(pos_q) > 32'(cnt_q) || cnt_q >= NONE) state_d = ST_DONE;
          else if (!used_q[cur_ix] || !cur_ok) state_d = ST_WALK;
        end else if (op_q == OP_FIND) begin
          state_d = ST_WALK;
        end else begin
          if (32'(pos_q) >= 32'(cnt_q)) state_d = ST_DONE;
          else state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        priority if (op_q == OP_FIND) begin
          if (idx_q >= cnt_q || !cur_ok || val_q[cur_ix] == v_q) state_d = ST_DONE;
        end else if (op_q == OP_INSERT && pos_ext == cnt_q) begin
          state_d = ST_LINK;
        end else if (idx_q == pos_ext || !cur_ok) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: state_d = (op_q == OP_READ) ? ST_DONE : ST_LINK;
      ST_LINK:  state_d = ST_FIX;
      ST_FIX:   state_d = ST_DONE;
      ST_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    req_ready_o = (state_q == ST_IDLE);
    rsp_valid_o = rsp_valid_q;
    rsp_o       = rsp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= NONE;
      tail_q      <= NONE;
      cnt_q       <= '0;
      used_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Load a new result or drop the accepted one.
      if (state_q == ST_DONE && (!rsp_valid_q || rsp_ready_i)) rsp_valid_q <= 1'b1;
      else if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q  <= op_e'(req_i.op);
            pos_q <= req_i.position;
            v_q   <= DATA_WIDTH'(req_i.item_value);
            cur_q <= '0;
            idx_q <= '0;
            ok_q  <= 1'b0;
            rv_q  <= '0;
            fp_q  <= '0;
          end
        end
        ST_FREE: begin
          // Scan for lowest free slot, then seed the walk at the head.
          if (op_q != OP_INSERT || !cur_ok || !used_q[cur_ix]) begin
            free_q <= cur_q;
            cur_q  <= head_q;
            idx_q  <= '0;
          end else begin
            cur_q <= cur_q + 1'b1;
          end
        end
        ST_WALK: begin
          if (op_q == OP_FIND) begin
            if (idx_q < cnt_q && cur_ok && val_q[cur_ix] == v_q) begin
              ok_q <= 1'b1;
              fp_q <= idx_q;
            end else if (cur_ok) begin
              cur_q <= next_q[cur_ix];
              idx_q <= idx_q + 1'b1;
            end
          end else if (!(op_q == OP_INSERT && pos_ext == cnt_q)
                       && idx_q != pos_ext && cur_ok) begin
            cur_q <= next_q[cur_ix];
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_FETCH: begin
          // cur_q is the slot at the position (successor for insert).
          if (cur_ok) begin
            pred_q <= prev_q[cur_ix];
            if (op_q == OP_READ) begin
              ok_q <= 1'b1;
              rv_q <= val_q[cur_ix];
            end
          end
        end
        ST_LINK: begin
          if (op_q == OP_INSERT) begin
            ok_q <= 1'b1;
            used_q[free_q[IW-1:0]] <= 1'b1;
            val_q[free_q[IW-1:0]]  <= v_q;
            cnt_q <= cnt_q + 1'b1;
            if (pos_ext == cnt_q) begin
              prev_q[free_q[IW-1:0]] <= tail_q;
              next_q[free_q[IW-1:0]] <= NONE;
              if (tail_q < NONE) next_q[tail_q[IW-1:0]] <= free_q;
              else head_q <= free_q;
              tail_q <= free_q;
            end else begin
              prev_q[free_q[IW-1:0]] <= pred_q;
              next_q[free_q[IW-1:0]] <= cur_q;
              prev_q[cur_ix] <= free_q;
            end
          end else if (cur_ok) begin
            // Erase: bypass the slot; pred_q holds prev, next read here.
            ok_q <= 1'b1;
            used_q[cur_ix] <= 1'b0;
            cnt_q <= cnt_q - 1'b1;
            free_q <= next_q[cur_ix];
            if (pred_q < NONE) next_q[pred_q[IW-1:0]] <= next_q[cur_ix];
            else head_q <= next_q[cur_ix];
          end
        end
        ST_FIX: begin
          if (op_q == OP_INSERT) begin
            if (pos_ext != cnt_q - 1'b1) begin
              if (pred_q < NONE) next_q[pred_q[IW-1:0]] <= free_q;
              else head_q <= free_q;
            end
          end else if (ok_q) begin
            if (free_q < NONE) prev_q[free_q[IW-1:0]] <= pred_q;
            else tail_q <= pred_q;
            next_q[cur_ix] <= NONE;
            prev_q[cur_ix] <= NONE;
          end
        end
        ST_DONE: begin
          if (!rsp_valid_q || rsp_ready_i) begin
            rsp_q.ok             <= ok_q;
            rsp_q.read_value     <= 32'(rv_q);
            rsp_q.found_position <= fp_q[3:0] & {4{ok_q}};
            rsp_q.entry_count    <= 5'(cnt_q);
            rsp_q.is_full        <= (cnt_q == NONE);
            rsp_q.is_empty       <= (cnt_q == '0);
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NONE) else $error("count above capacity");
  a_used_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> $countones(used_q) == 32'(cnt_q))
    else $error("used bits disagree with count");
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && cnt_q == '0) |-> (head_q == NONE && tail_q == NONE))
    else $error("empty list with live head");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !req_ready_o) else $error("ready while busy");
`endif

endmodule
